FILE: rtl/dgct_pkg.sv
// Shared constants and types for the directional gate crossing test.
`timescale 1ns / 1ps
`default_nettype none

package dgct_pkg;

    // Default coordinate format, signed Q16.16
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Limb width of the partial products inside the wide multipliers
    localparam int LIMB_W = 32;

    // Register stages from the operands to the product of one wide multiplier
    localparam int MUL_LAT = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_FORWARD_X  = 3'd2,
        CFG_FORWARD_Y  = 3'd3,
        CFG_HALF_WIDTH = 3'd4
    } t_cfg_reg;

endpackage

`default_nettype wire

FILE: rtl/dgct_if.sv
// Valid/ready channel interfaces for position items and crossing results.
`timescale 1ns / 1ps
`default_nettype none

interface dgct_in_if #(
    parameter int COORD_WIDTH = dgct_pkg::COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] prev_x;
    logic signed [COORD_WIDTH-1:0] prev_y;
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;

    modport source (
        output valid, prev_x, prev_y, cur_x, cur_y,
        input  ready
    );

    modport sink (
        input  valid, prev_x, prev_y, cur_x, cur_y,
        output ready
    );
endinterface

interface dgct_out_if ();
    logic valid;
    logic ready;
    logic crossed;
    logic gate_invalid;

    modport source (
        output valid, crossed, gate_invalid,
        input  ready
    );

    modport sink (
        input  valid, crossed, gate_invalid,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/dgct_mul.sv
// Pipelined wide unsigned multiplier built from limb-sized partial products.
`timescale 1ns / 1ps
`default_nettype none

// Four register stages: partial products, row sums, row pairs, final sum.
// The row-pair tree covers every row of the operand i_a.
module dgct_mul #(
    parameter int WA = dgct_pkg::COORD_WIDTH,
    parameter int WB = dgct_pkg::COORD_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WA-1:0]    i_a,
    input  wire logic [WB-1:0]    i_b,
    output logic      [WA+WB-1:0] o_p
);
    localparam int LW  = dgct_pkg::LIMB_W;
    localparam int NA  = (WA + LW - 1) / LW;
    localparam int NB  = (WB + LW - 1) / LW;
    localparam int NP  = (NA + 1) / 2;
    localparam int AW  = LW * NA;
    localparam int BW  = LW * NB;
    localparam int RW  = LW * (NB + 1);
    localparam int PRW = LW * (NB + 2);
    localparam int TW  = LW * (NA + NB);

    logic [AW-1:0]   w_a;
    logic [BW-1:0]   w_b;
    logic [2*LW-1:0] r_pp [NA][NB];
    logic [RW-1:0]   w_ev [NA];
    logic [RW-1:0]   w_od [NA];
    logic [RW-1:0]   r_row [NA];
    logic [PRW-1:0]  w_pair [NP];
    logic [PRW-1:0]  r_pair [NP];
    logic [TW-1:0]   w_tot;
    logic [TW-1:0]   r_tot;

    assign w_a = AW'(i_a);
    assign w_b = BW'(i_b);

    // Lay even and odd partial products of a row side by side without overlap
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_ev[i] = '0;
            w_od[i] = '0;
            for (int j = 0; j < NB; j += 2) begin
                w_ev[i][LW*j +: 2*LW] = r_pp[i][j];
            end
            for (int j = 1; j < NB; j += 2) begin
                w_od[i][LW*j +: 2*LW] = r_pp[i][j];
            end
        end
    end

    // Combine neighbouring rows
    for (genvar k = 0; k < NP; k++) begin : g_pair
        if (2 * k + 1 < NA) begin : g_two
            assign w_pair[k] = PRW'(r_row[2*k]) + (PRW'(r_row[2*k+1]) << LW);
        end else begin : g_one
            assign w_pair[k] = PRW'(r_row[2*k]);
        end
    end

    // Final sum of the row pairs
    always_comb begin
        w_tot = '0;
        for (int k = 0; k < NP; k++) begin
            w_tot = w_tot + (TW'(r_pair[k]) << (2 * LW * k));
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= w_a[LW*i +: LW] * w_b[LW*j +: LW];
                end
                r_row[i] <= w_ev[i] + w_od[i];
            end
            r_pair <= w_pair;
            r_tot  <= w_tot;
        end
    end

    assign o_p = r_tot[WA+WB-1:0];

endmodule

`default_nettype wire

FILE: rtl/directional_gate_crossing_test.sv
// Top level: forward crossing test of a step against a configured gate line.
//
//  Channel   Direction  Handshake           Payload
//  i_in      in         valid/ready         prev_x, prev_y, cur_x, cur_y
//  o_out     out        valid/ready         crossed, gate_invalid
//  i_cfg_*   in         write enable only   register index, write data
//
// One item is accepted per cycle while the skid entry is empty. A result
// passes three chained wide multiplier groups of MUL_LAT stages each on its
// way to o_out. Reset clears the stage valid bits and the output slots and
// loads the gate registers with their defaults. An output register plus one
// skid entry absorb a stalled sink; the pipeline freezes as a whole only
// while the skid entry is occupied.
`timescale 1ns / 1ps
`default_nettype none

module directional_gate_crossing_test #(
    parameter int COORD_WIDTH = dgct_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = dgct_pkg::FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    dgct_in_if.sink                             i_in,
    dgct_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [dgct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0]         i_cfg_data
);
    localparam int W    = COORD_WIDTH;
    localparam int HWW  = W - 1;
    localparam int DW   = W + 1;
    localparam int SW   = 2 * W + 3;
    localparam int MW   = 2 * W + 2;
    localparam int SQW  = 2 * MW;
    localparam int F2W  = 2 * W;
    localparam int H2W  = 2 * HWW;
    localparam int CW   = F2W + SQW;

    // Stage numbers
    localparam int S1   = 1;
    localparam int SG1  = S1 + dgct_pkg::MUL_LAT;
    localparam int SSUM = SG1 + 1;
    localparam int SABS = SSUM + 1;
    localparam int SG2  = SABS + dgct_pkg::MUL_LAT;
    localparam int SG3  = SG2 + dgct_pkg::MUL_LAT;
    localparam int SCMP = SG3 + 1;

    localparam logic [W-1:0]   FWD_RST = W'(64'd1 << FRAC_BITS);
    localparam logic [HWW-1:0] HW_RST  = HWW'(64'd1 << FRAC_BITS);

    // Gate registers
    logic [W-1:0]   r_cx;
    logic [W-1:0]   r_cy;
    logic [W-1:0]   r_fx;
    logic [W-1:0]   r_fy;
    logic [HWW-1:0] r_hw;

    // Handshake and stage valid bits
    logic            w_en;
    logic            w_acc;
    logic [SCMP:1]   r_v;
    logic [SCMP:1]   r_inv;

    // Stage 1
    logic [DW-1:0]   w_dif [6];
    logic [DW-1:0]   w_md [6];
    logic [5:0]      w_sd;
    logic [7:0]      w_sgn;
    logic [W-1:0]    w_mfx;
    logic [W-1:0]    w_mfy;
    logic            w_inv;
    logic [DW-1:0]   r1_md [6];
    logic [W-1:0]    r1_mfx;
    logic [W-1:0]    r1_mfy;
    logic [HWW-1:0]  r1_hw;
    logic [7:0]      r_sgn [S1:SG1];

    // First multiplier group outputs
    logic [W+DW-1:0] w_pd [6];
    logic [2*DW-1:0] w_px [2];
    logic [F2W-1:0]  w_fx2;
    logic [F2W-1:0]  w_fy2;
    logic [H2W-1:0]  w_h2;

    // Sums, magnitudes and direction flag
    logic [SW-1:0]   r6_sp;
    logic [SW-1:0]   r6_sc;
    logic [SW-1:0]   r6_d;
    logic [SW-1:0]   r6_x;
    logic [F2W-1:0]  r_f2 [SSUM:SG2];
    logic [H2W-1:0]  r_h2 [SSUM:SG2];
    logic            w_dir;
    logic [SG3:SABS] r_dir;
    logic [MW-1:0]   r7_mx;
    logic [MW-1:0]   r7_md;

    // Second and third multiplier group outputs
    logic [SQW-1:0]  w_x2;
    logic [SQW-1:0]  w_d2;
    logic [CW-1:0]   w_lhs;
    logic [CW-3:0]   w_rhs;
    logic            r_cross;

    // Output register and skid entry
    logic            w_take;
    logic            w_push;
    logic            r_ov;
    logic            r_sv;
    logic            r_o_cross;
    logic            r_o_inv;
    logic            r_s_cross;
    logic            r_s_inv;

    // Two's complement sum of two sign/magnitude terms
    function automatic logic [SW-1:0] f_sadd(
        input logic [SW-1:0] a,
        input logic          sa,
        input logic [SW-1:0] b,
        input logic          sb
    );
        return (sa ? ~a : a) + (sb ? ~b : b) + SW'(sa) + SW'(sb);
    endfunction

    // Magnitude of a two's complement sum
    function automatic logic [MW-1:0] f_abs(input logic [SW-1:0] v);
        logic [SW-1:0] t;
        t = v[SW-1] ? (~v + SW'(1)) : v;
        return t[MW-1:0];
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_fx <= FWD_RST;
            r_fy <= '0;
            r_hw <= HW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dgct_pkg::CFG_CENTER_X:   r_cx <= i_cfg_data;
                dgct_pkg::CFG_CENTER_Y:   r_cy <= i_cfg_data;
                dgct_pkg::CFG_FORWARD_X:  r_fx <= i_cfg_data;
                dgct_pkg::CFG_FORWARD_Y:  r_fy <= i_cfg_data;
                dgct_pkg::CFG_HALF_WIDTH: r_hw <= i_cfg_data[HWW-1:0];
                default: ;
            endcase
        end
    end

    // Hold the pipeline only while the skid entry is taken
    assign w_en       = !r_sv;
    assign w_acc      = i_in.valid && w_en;
    assign i_in.ready = w_en;

    // Offsets from the gate centre and the step, as sign and magnitude
    always_comb begin
        w_dif[0] = {i_in.prev_x[W-1], i_in.prev_x} - {r_cx[W-1], r_cx};
        w_dif[1] = {i_in.prev_y[W-1], i_in.prev_y} - {r_cy[W-1], r_cy};
        w_dif[2] = {i_in.cur_x[W-1], i_in.cur_x} - {r_cx[W-1], r_cx};
        w_dif[3] = {i_in.cur_y[W-1], i_in.cur_y} - {r_cy[W-1], r_cy};
        w_dif[4] = {i_in.cur_x[W-1], i_in.cur_x} - {i_in.prev_x[W-1], i_in.prev_x};
        w_dif[5] = {i_in.cur_y[W-1], i_in.cur_y} - {i_in.prev_y[W-1], i_in.prev_y};
        for (int k = 0; k < 6; k++) begin
            w_sd[k] = w_dif[k][DW-1];
            w_md[k] = w_sd[k] ? (~w_dif[k] + DW'(1)) : w_dif[k];
        end
        w_mfx = r_fx[W-1] ? (~r_fx + W'(1)) : r_fx;
        w_mfy = r_fy[W-1] ? (~r_fy + W'(1)) : r_fy;
        // Product signs: three dot products, then the two cross terms
        for (int k = 0; k < 6; k++) begin
            w_sgn[k] = w_sd[k] ^ ((k % 2 == 0) ? r_fx[W-1] : r_fy[W-1]);
        end
        w_sgn[6] = w_sd[2] ^ w_sd[1];
        w_sgn[7] = !(w_sd[3] ^ w_sd[0]);
        w_inv = ((r_fx == '0) && (r_fy == '0)) || (r_hw == '0);
    end

    // Forward side test on the stage-6 sums
    assign w_dir = (r6_sp[SW-1] || (r6_sp == '0)) && !r6_sc[SW-1] && (r6_sc != '0);

    // Advance stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[SCMP-1:1], w_acc};
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inv <= {r_inv[SCMP-1:1], w_inv};

            r1_md  <= w_md;
            r1_mfx <= w_mfx;
            r1_mfy <= w_mfy;
            r1_hw  <= r_hw;
            r_sgn[S1] <= w_sgn;
            for (int k = S1 + 1; k <= SG1; k++) begin
                r_sgn[k] <= r_sgn[k-1];
            end

            r6_sp <= f_sadd(SW'(w_pd[0]), r_sgn[SG1][0], SW'(w_pd[1]), r_sgn[SG1][1]);
            r6_sc <= f_sadd(SW'(w_pd[2]), r_sgn[SG1][2], SW'(w_pd[3]), r_sgn[SG1][3]);
            r6_d  <= f_sadd(SW'(w_pd[4]), r_sgn[SG1][4], SW'(w_pd[5]), r_sgn[SG1][5]);
            r6_x  <= f_sadd(SW'(w_px[0]), r_sgn[SG1][6], SW'(w_px[1]), r_sgn[SG1][7]);
            r_f2[SSUM] <= w_fx2 + w_fy2;
            r_h2[SSUM] <= w_h2;
            for (int k = SSUM + 1; k <= SG2; k++) begin
                r_f2[k] <= r_f2[k-1];
                r_h2[k] <= r_h2[k-1];
            end

            r_dir <= {r_dir[SG3-1:SABS], w_dir};
            r7_mx <= f_abs(r6_x);
            r7_md <= f_abs(r6_d);

            r_cross <= !r_inv[SG3] && r_dir[SG3] && (w_lhs <= CW'(w_rhs));
        end
    end

    // Dot products of the offsets and the step with the forward vector
    for (genvar k = 0; k < 6; k++) begin : g_dot
        dgct_mul #(
            .WA (W),
            .WB (DW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   ((k % 2 == 0) ? r1_mfx : r1_mfy),
            .i_b   (r1_md[k]),
            .o_p   (w_pd[k])
        );
    end

    // Cross product terms of the two offsets
    dgct_mul #(.WA(DW), .WB(DW)) u_cross_a (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_md[2]), .i_b (r1_md[1]), .o_p (w_px[0])
    );
    dgct_mul #(.WA(DW), .WB(DW)) u_cross_b (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_md[3]), .i_b (r1_md[0]), .o_p (w_px[1])
    );

    // Squared forward length and squared half width
    dgct_mul #(.WA(W), .WB(W)) u_fx_sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_mfx), .i_b (r1_mfx), .o_p (w_fx2)
    );
    dgct_mul #(.WA(W), .WB(W)) u_fy_sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_mfy), .i_b (r1_mfy), .o_p (w_fy2)
    );
    dgct_mul #(.WA(HWW), .WB(HWW)) u_hw_sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_hw), .i_b (r1_hw), .o_p (w_h2)
    );

    // Square the cross product and the step's forward distance
    dgct_mul #(.WA(MW), .WB(MW)) u_x_sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r7_mx), .i_b (r7_mx), .o_p (w_x2)
    );
    dgct_mul #(.WA(MW), .WB(MW)) u_d_sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r7_md), .i_b (r7_md), .o_p (w_d2)
    );

    // Scale both sides of the lateral test
    dgct_mul #(.WA(F2W), .WB(SQW)) u_lhs (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_f2[SG2]), .i_b (w_x2), .o_p (w_lhs)
    );
    dgct_mul #(.WA(H2W), .WB(SQW)) u_rhs (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_h2[SG2]), .i_b (w_d2), .o_p (w_rhs)
    );

    // Output register with one skid entry
    assign w_take = r_ov && o_out.ready;
    assign w_push = w_en && r_v[SCMP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!r_ov || w_take) begin
                r_o_cross <= r_s_cross;
                r_o_inv   <= r_s_inv;
            end
        end else if (w_push) begin
            if (!r_ov || w_take) begin
                r_o_cross <= r_cross;
                r_o_inv   <= r_inv[SCMP];
            end else begin
                r_s_cross <= r_cross;
                r_s_inv   <= r_inv[SCMP];
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.crossed      = r_o_cross;
    assign o_out.gate_invalid = r_o_inv;

    // The skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry holds an item while the output register is empty");

    // An invalid gate never reports a crossing
    a_invalid_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.gate_invalid) |-> !o_out.crossed)
        else $error("crossing reported for an invalid gate");

    // A full skid entry freezes the last stage
    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && r_v[SCMP]) |=> (r_v[SCMP] && $stable(r_cross)))
        else $error("last stage changed during a stall");

    // Reset empties both output slots
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !r_sv))
        else $error("output slots not cleared by reset");

endmodule

`default_nettype wire
